[rtl/core/emrg_pkg.sv]
// Package for the maze row generator core: constants, payload and state types.
// Used by eller_maze_row_generator_core; depends on nothing.
`default_nettype none
package emrg_pkg;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int LABEL_BITS_DEF = 32;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
  localparam logic [6:0] RUN_SAT = 7'd127;
  localparam logic [15:0] JOIN_MOD_DEF = 16'd3;
  localparam logic [15:0] DOWN_MOD_DEF = 16'd5;
  localparam logic [6:0] ROW_WIDTH_RST = 7'd16;

  localparam logic [2:0] REG_ROW_WIDTH = 3'd0;
  localparam logic [2:0] REG_SET_LIMIT = 3'd1;
  localparam logic [2:0] REG_JOIN_MOD  = 3'd2;
  localparam logic [2:0] REG_DOWN_MOD  = 3'd3;
  localparam logic [2:0] REG_SEED      = 3'd4;

  localparam logic ACT_START = 1'b0;

  typedef struct packed {
    logic action;
    logic final_row;
  } cmd_t;

  typedef struct packed {
    logic [5:0] column;
    logic       right_open;
    logic       down_open;
    logic       row_end;
  } cell_t;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_COPY   = 18'h00002,
    S_LABEL  = 18'h00004,
    S_JRD    = 18'h00008,
    S_JRB    = 18'h00010,
    S_JCMP   = 18'h00020,
    S_JDRAW  = 18'h00040,
    S_JMOD   = 18'h00080,
    S_RELAB  = 18'h00100,
    S_BSCAN  = 18'h00200,
    S_BLS    = 18'h00400,
    S_BCMP   = 18'h00800,
    S_BDRAW  = 18'h01000,
    S_BMOD   = 18'h02000,
    S_PDRAW  = 18'h04000,
    S_PMOD   = 18'h08000,
    S_FJOIN  = 18'h10000,
    S_OUT    = 18'h20000
  } state_t;
endpackage
`default_nettype wire

[rtl/core/emrg_mod.sv]
// Shared serial modulo unit: 16-bit value reduced modulo a 16-bit divisor.
// Restoring division, one quotient bit per cycle; uses no package items.
`default_nettype none
module emrg_mod (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [15:0] num,
  input  wire logic [15:0] den,
  output logic             done,
  output logic [15:0]      rem
);
  logic [15:0] q;
  logic [16:0] r;
  logic [4:0]  cnt;
  logic        run;
  logic [16:0] trial;

  assign trial = {r[15:0], q[15]};
  assign rem   = r[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        q   <= num;
        r   <= '0;
        cnt <= 5'd16;
      end else if (run) begin
        q <= {q[14:0], 1'b0};
        if (trial >= {1'b0, den}) r <= trial - {1'b0, den};
        else r <= trial;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/eller_maze_row_generator_core.sv]
// Top level of the maze row generator: sequencer, label stores and APB registers.
// Depends on emrg_pkg and emrg_mod.
// A final row takes an extra join pass before its results; each draw holds the shared serial
// modulo unit and each join relabels the row one cell a cycle. Results then leave one cell a
// cycle; the receiver cannot stall. A maze start is taken with no results. One item at a
// time. Reset is synchronous; stored next-row labels read as unassigned.
`default_nettype none
module eller_maze_row_generator_core #(
  parameter int MAX_WIDTH  = emrg_pkg::MAX_WIDTH_DEF,
  parameter int LABEL_BITS = emrg_pkg::LABEL_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire emrg_pkg::cmd_t cmd,
  output logic               busy,
  output logic               result_valid,
  output emrg_pkg::cell_t    result,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int XB = $clog2(MAX_WIDTH);
  localparam int CB = XB + 1;

  logic [6:0]  row_width, set_size_limit;
  logic [15:0] join_modulus, down_modulus;
  logic [31:0] random_seed;

  emrg_pkg::state_t state;
  logic [LABEL_BITS-1:0] row_labels [MAX_WIDTH];
  logic [LABEL_BITS-1:0] nxt_labels [MAX_WIDTH];
  logic [MAX_WIDTH-1:0]  nxt_valid, rwall, dwall;
  logic [LABEL_BITS-1:0] next_label;
  logic [31:0] random_state;
  logic [6:0]  run_size;
  logic        last;
  logic [XB-1:0] x, i, rs, re;
  logic [CB-1:0] w;
  logic [LABEL_BITS-1:0] la, lb, from_l, to_l, ls;
  logic [6:0] cnt;
  logic       fin;
  logic [XB-1:0] rx, rx_q;
  logic          rv;
  logic [XB-1:0] rd_addr;
  logic [LABEL_BITS-1:0] rd_q, nl_q;
  logic          nv_q;

  // APB
  assign pready = 1'b1;
  wire [2:0] ridx = paddr[4:2];
  always_comb begin
    case (ridx)
      emrg_pkg::REG_ROW_WIDTH: prdata = {25'd0, row_width};
      emrg_pkg::REG_SET_LIMIT: prdata = {25'd0, set_size_limit};
      emrg_pkg::REG_JOIN_MOD:  prdata = {16'd0, join_modulus};
      emrg_pkg::REG_DOWN_MOD:  prdata = {16'd0, down_modulus};
      emrg_pkg::REG_SEED:      prdata = random_seed;
      default:                 prdata = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width      <= emrg_pkg::ROW_WIDTH_RST;
      set_size_limit <= '0;
      join_modulus   <= emrg_pkg::JOIN_MOD_DEF;
      down_modulus   <= emrg_pkg::DOWN_MOD_DEF;
      random_seed    <= 32'd1;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        emrg_pkg::REG_ROW_WIDTH: row_width <= pwdata[6:0];
        emrg_pkg::REG_SET_LIMIT: set_size_limit <= pwdata[6:0];
        emrg_pkg::REG_JOIN_MOD:  join_modulus <= pwdata[15:0];
        emrg_pkg::REG_DOWN_MOD:  down_modulus <= pwdata[15:0];
        emrg_pkg::REG_SEED:      random_seed <= pwdata;
        default: ;
      endcase
    end
  end

  // LFSR step and shared modulo
  logic [31:0] lfsr_nx;
  assign lfsr_nx = random_state[0] ? ((random_state >> 1) ^ emrg_pkg::LFSR_MASK)
                                   : (random_state >> 1);
  logic        mgo, mdone;
  logic [15:0] mden, mrem;
  emrg_mod u_mod (.clk(clk), .rst(rst), .go(mgo), .num(lfsr_nx[15:0]), .den(mden),
                  .done(mdone), .rem(mrem));

  logic [15:0] jm, dm;
  assign jm = (join_modulus == 16'd0) ? emrg_pkg::JOIN_MOD_DEF : join_modulus;
  assign dm = (down_modulus == 16'd0) ? emrg_pkg::DOWN_MOD_DEF : down_modulus;
  logic [CB-1:0] wc;
  always_comb begin
    if (row_width == 7'd0) wc = CB'(1);
    else if (32'(row_width) > MAX_WIDTH) wc = CB'(MAX_WIDTH);
    else wc = CB'(row_width);
  end
  wire [CB-1:0] runlen = CB'(re) - CB'(rs) + CB'(1);

  always_comb begin
    mgo  = 1'b0;
    mden = dm;
    case (state)
      emrg_pkg::S_JDRAW: begin mgo = 1'b1; mden = jm; end
      emrg_pkg::S_BDRAW: begin mgo = 1'b1; mden = dm; end
      emrg_pkg::S_PDRAW: begin mgo = 1'b1; mden = 16'(runlen); end
      emrg_pkg::S_JMOD:  mden = jm;
      emrg_pkg::S_PMOD:  mden = 16'(runlen);
      default: ;
    endcase
  end

  assign busy = (state != emrg_pkg::S_IDLE);
  wire [LABEL_BITS-1:0] nl_inc = next_label + LABEL_BITS'(1);
  wire [CB-1:0] x1 = CB'(x) + CB'(1);
  wire [CB-1:0] i1 = CB'(i) + CB'(1);
  wire          hit = rv && (rd_q == from_l);
  wire [7:0] run_sum = {1'b0, run_size} + {1'b0, cnt} + {7'd0, hit};

  // label store read port: one address a cycle, data registered
  always_comb begin
    case (state)
      emrg_pkg::S_JRB:   rd_addr = XB'(x1);
      emrg_pkg::S_RELAB: rd_addr = rx;
      emrg_pkg::S_BSCAN: rd_addr = rs;
      emrg_pkg::S_BLS:   rd_addr = XB'(CB'(re) + CB'(1));
      emrg_pkg::S_BCMP:  rd_addr = XB'(CB'(re) + CB'(2));
      default:           rd_addr = x;
    endcase
  end
  always_ff @(posedge clk) begin
    rd_q <= row_labels[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= emrg_pkg::S_IDLE;
      nxt_valid <= '0;
      next_label <= LABEL_BITS'(1);
      random_state <= 32'd1;
      run_size <= 7'd1;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        emrg_pkg::S_IDLE: if (start) begin
          last <= cmd.final_row;
          if (cmd.action == emrg_pkg::ACT_START) begin
            nxt_valid <= '0;
            next_label <= LABEL_BITS'(1);
            random_state <= (random_seed != 32'd0) ? random_seed : 32'd1;
          end else begin
            w <= wc; x <= '0; rwall <= '0; dwall <= '0;
            state <= emrg_pkg::S_COPY;
          end
        end
        emrg_pkg::S_COPY: begin
          nl_q <= nxt_labels[x];
          nv_q <= nxt_valid[x];
          state <= emrg_pkg::S_LABEL;
        end
        // copy next-row labels in, labelling unassigned cells
        emrg_pkg::S_LABEL: begin
          if (nv_q && nl_q != '0) row_labels[x] <= nl_q;
          else begin
            row_labels[x] <= next_label;
            next_label <= (nl_inc == '0) ? LABEL_BITS'(1) : nl_inc;
          end
          if (x1 == w) begin
            x <= '0; run_size <= 7'd1; fin <= 1'b0;
            nxt_valid <= '0;
            state <= (w == CB'(1)) ? emrg_pkg::S_BSCAN : emrg_pkg::S_JRD;
            rs <= '0; re <= '0;
          end else begin
            x <= XB'(x1);
            state <= emrg_pkg::S_COPY;
          end
        end
        emrg_pkg::S_JRD: state <= emrg_pkg::S_JRB;
        emrg_pkg::S_JRB: begin
          la <= rd_q;
          state <= emrg_pkg::S_JCMP;
        end
        emrg_pkg::S_JCMP: begin
          lb <= rd_q;
          if (fin) begin
            if (la != rd_q) begin
              rwall[x] <= 1'b1;
              from_l <= rd_q; to_l <= la;
              rx <= '0; cnt <= '0; rv <= 1'b0; state <= emrg_pkg::S_RELAB;
            end else state <= emrg_pkg::S_FJOIN;
          end else if (la == rd_q) begin
            run_size <= 7'd1; state <= emrg_pkg::S_FJOIN;
          end else state <= emrg_pkg::S_JDRAW;
        end
        emrg_pkg::S_JDRAW: begin
          random_state <= lfsr_nx; state <= emrg_pkg::S_JMOD;
        end
        emrg_pkg::S_JMOD: if (mdone) begin
          if (mrem == 16'd0 ||
              (set_size_limit != 7'd0 && run_size >= set_size_limit)) begin
            run_size <= 7'd1; state <= emrg_pkg::S_FJOIN;
          end else begin
            rwall[x] <= 1'b1;
            from_l <= lb; to_l <= la;
            rx <= '0; cnt <= '0; rv <= 1'b0; state <= emrg_pkg::S_RELAB;
          end
        end
        // relabel the merged set one cell a cycle, compare one cell behind the read
        emrg_pkg::S_RELAB: begin
          if (rv) begin
            if (hit) begin
              row_labels[rx_q] <= to_l;
              if (cnt != 7'd127) cnt <= cnt + 7'd1;
            end
            if (CB'(rx_q) + CB'(1) == w) begin
              if (!fin) run_size <= (run_sum > 8'(emrg_pkg::RUN_SAT)) ? emrg_pkg::RUN_SAT
                                                                  : run_sum[6:0];
              state <= emrg_pkg::S_FJOIN;
            end
          end
          rv <= 1'b1;
          rx_q <= rx;
          rx <= XB'(CB'(rx) + CB'(1));
        end
        // advance the join walk
        emrg_pkg::S_FJOIN: begin
          if (x1 + CB'(1) >= w) begin
            x <= '0;
            if (fin) begin dwall <= '0; i <= '0; state <= emrg_pkg::S_OUT; end
            else begin rs <= '0; re <= '0; i <= '0; state <= emrg_pkg::S_BSCAN; end
          end else begin
            x <= XB'(x1); state <= emrg_pkg::S_JRD;
          end
        end
        // find the end of the run starting at rs
        emrg_pkg::S_BSCAN: state <= emrg_pkg::S_BLS;
        emrg_pkg::S_BLS: begin
          ls <= rd_q;
          state <= emrg_pkg::S_BCMP;
        end
        emrg_pkg::S_BCMP: begin
          if (CB'(re) + CB'(1) < w && rd_q == ls)
            re <= XB'(CB'(re) + CB'(1));
          else begin
            i <= rs; state <= emrg_pkg::S_BDRAW;
          end
        end
        emrg_pkg::S_BDRAW: begin
          random_state <= lfsr_nx; state <= emrg_pkg::S_BMOD;
        end
        emrg_pkg::S_BMOD: if (mdone) begin
          if (mrem == 16'd0) begin
            dwall[i] <= 1'b1;
            if (!last) begin nxt_labels[i] <= ls; nxt_valid[i] <= 1'b1; end
          end
          if (i == re) state <= emrg_pkg::S_PDRAW;
          else begin i <= XB'(i1); state <= emrg_pkg::S_BDRAW; end
        end
        emrg_pkg::S_PDRAW: begin
          random_state <= lfsr_nx; state <= emrg_pkg::S_PMOD;
        end
        emrg_pkg::S_PMOD: if (mdone) begin
          dwall[XB'(CB'(rs) + CB'(mrem))] <= 1'b1;
          if (!last) begin
            nxt_labels[XB'(CB'(rs) + CB'(mrem))] <= ls;
            nxt_valid[XB'(CB'(rs) + CB'(mrem))] <= 1'b1;
          end
          if (CB'(re) + CB'(1) == w) begin
            i <= '0;
            if (last && w != CB'(1)) begin
              fin <= 1'b1; x <= '0; state <= emrg_pkg::S_JRD;
            end else begin
              if (last) dwall <= '0;
              state <= emrg_pkg::S_OUT;
            end
          end else begin
            rs <= XB'(CB'(re) + CB'(1)); re <= XB'(CB'(re) + CB'(1));
            state <= emrg_pkg::S_BSCAN;
          end
        end
        emrg_pkg::S_OUT: begin
          result_valid <= 1'b1;
          result.column <= 6'(i);
          result.right_open <= rwall[i] && (i1 != w);
          result.down_open <= dwall[i];
          result.row_end <= (i1 == w);
          if (i1 == w) state <= emrg_pkg::S_IDLE;
          else i <= XB'(i1);
        end
        default: state <= emrg_pkg::S_IDLE;
      endcase
    end
  end

  // a result other than a row end never appears while idle
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.row_end |-> busy) else $error("result outside a row");
  a_row_end_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.row_end |-> !busy) else $error("row end without return to idle");
  a_last_wall: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.row_end |-> !result.right_open) else $error("last cell open right");
endmodule
`default_nettype wire
